// File: rtl/ldnw_pkg.sv
// Shared types, constants, divide-by-ten helper and microcode ROM for the LCD number writer.
package ldnw_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PC_W = 3;

    localparam logic [7:0] ADDR_BASE = 8'h80;
    localparam logic [7:0] ROW_STEP = 8'h40;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [31:0] RADIX = 32'd10;
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int DIV10_SHIFT = 35;

    typedef logic [PC_W-1:0] upc_t;

    // microcode step addresses
    localparam upc_t UA_WAIT = 3'd0;
    localparam upc_t UA_COUNT = 3'd1;
    localparam upc_t UA_DIV = 3'd2;
    localparam upc_t UA_REM = 3'd3;
    localparam upc_t UA_CMD_HI = 3'd4;
    localparam upc_t UA_CMD_LO = 3'd5;
    localparam upc_t UA_DAT_HI = 3'd6;
    localparam upc_t UA_DAT_LO = 3'd7;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_COUNT,
        OP_DIV,
        OP_REM,
        OP_EMIT
    } uop_t;

    typedef struct packed {
        uop_t op;
        logic rs;        // data vs command transfer
        logic lo_half;   // low nibble transfer, skipped in eight-bit mode
        logic loop;      // back to DIV while digits remain, else to WAIT
        upc_t target;
    } uword_t;

    // sequencer -> datapath strobes
    typedef struct packed {
        logic load;
        logic count;
        logic div;
        logic rem;
        logic emit;
        logic dec_pos;
        logic rs;
        logic lo_half;
        logic nib_mode;
        logic last;
    } ldnw_ctl_t;

    // datapath -> sequencer status
    typedef struct packed {
        logic more;
        logic pos_zero;
        logic out_free;
    } ldnw_stat_t;

    // exact floor(x / 10) for any 32-bit x
    function automatic logic [31:0] div10(input logic [31:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(DIV10_RECIP);
        return 32'(prod >> DIV10_SHIFT);
    endfunction

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = '{op: OP_WAIT, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_WAIT};
        case (pc)
            UA_WAIT: begin
                w = '{op: OP_WAIT, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_COUNT};
            end
            UA_COUNT: begin
                w = '{op: OP_COUNT, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_DIV};
            end
            UA_DIV: begin
                w = '{op: OP_DIV, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_REM};
            end
            UA_REM: begin
                w = '{op: OP_REM, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_CMD_HI};
            end
            UA_CMD_HI: begin
                w = '{op: OP_EMIT, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_CMD_LO};
            end
            UA_CMD_LO: begin
                w = '{op: OP_EMIT, rs: 1'b0, lo_half: 1'b1, loop: 1'b0, target: UA_DAT_HI};
            end
            UA_DAT_HI: begin
                w = '{op: OP_EMIT, rs: 1'b1, lo_half: 1'b0, loop: 1'b0, target: UA_DAT_LO};
            end
            UA_DAT_LO: begin
                w = '{op: OP_EMIT, rs: 1'b1, lo_half: 1'b1, loop: 1'b1, target: UA_DIV};
            end
            default: begin
                w = '{op: OP_WAIT, rs: 1'b0, lo_half: 1'b0, loop: 1'b0, target: UA_WAIT};
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ldnw_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module ldnw_seq import ldnw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       bus_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  ldnw_stat_t stat,
    output ldnw_ctl_t  ctl
);

    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t uw;
    upc_t   jump_pc;

    assign uw = ucode(pc_reg);
    assign s_ready = (uw.op == OP_WAIT);

    always_comb begin
        ctl = '0;
        ctl.rs = uw.rs;
        ctl.lo_half = uw.lo_half;
        ctl.nib_mode = bus_mode;
        // final transfer: data byte in eight-bit mode, its low nibble in four-bit mode
        ctl.last = uw.rs && stat.pos_zero && (uw.lo_half || !bus_mode);
        pc_next = pc_reg;

        if (uw.loop && !stat.pos_zero) begin
            jump_pc = uw.target;
        end else if (uw.loop) begin
            jump_pc = UA_WAIT;
        end else begin
            jump_pc = uw.target;
        end

        case (uw.op)
            OP_WAIT: begin
                ctl.load = s_valid;
                if (s_valid) begin
                    pc_next = uw.target;
                end
            end
            OP_COUNT: begin
                if (stat.more) begin
                    ctl.count = 1'b1;
                end else begin
                    pc_next = uw.target;
                end
            end
            OP_DIV: begin
                ctl.div = 1'b1;
                pc_next = uw.target;
            end
            OP_REM: begin
                ctl.rem = 1'b1;
                pc_next = uw.target;
            end
            OP_EMIT: begin
                if (uw.lo_half && !bus_mode) begin
                    // no low nibble in eight-bit mode
                    pc_next = jump_pc;
                    ctl.dec_pos = uw.loop && !stat.pos_zero;
                end else if (stat.out_free) begin
                    ctl.emit = 1'b1;
                    pc_next = jump_pc;
                    ctl.dec_pos = uw.loop && !stat.pos_zero;
                end
            end
            default: begin
                pc_next = UA_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UA_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: rtl/ldnw_dp.sv
// Datapath: digit count, divide by ten, address/character forming and output register.
module ldnw_dp import ldnw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ldnw_ctl_t   ctl,
    output ldnw_stat_t  stat,
    input  logic [31:0] s_number,
    input  logic [1:0]  s_row,
    input  logic [5:0]  s_col,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic [7:0]  m_bus_value,
    output logic        m_last
);

    logic [31:0]      num_reg;
    logic [31:0]      tmp_reg;
    logic [31:0]      q_reg;
    logic [3:0]       digit_reg;
    logic [7:0]       base_reg;
    logic [POS_W-1:0] pos_reg;
    logic             m_valid_reg;
    logic             m_rs_reg;
    logic [7:0]       m_value_reg;
    logic             m_last_reg;

    logic [31:0]      mul_in;
    logic [31:0]      quot;
    logic [31:0]      q_times10;
    logic [7:0]       byte_val;
    logic [7:0]       xfer_val;

    // one shared multiply-by-reciprocal unit
    assign mul_in = ctl.count ? tmp_reg : num_reg;
    assign quot = div10(mul_in);
    assign q_times10 = {q_reg[28:0], 3'b000} + {q_reg[30:0], 1'b0};

    assign byte_val = ctl.rs ? (ASCII_ZERO + {4'b0000, digit_reg})
                             : (base_reg + 8'(pos_reg));
    always_comb begin
        if (!ctl.nib_mode) begin
            xfer_val = byte_val;
        end else if (ctl.lo_half) begin
            xfer_val = {byte_val[3:0], 4'b0000};
        end else begin
            xfer_val = byte_val & NIBBLE_MASK;
        end
    end

    assign stat.more = (tmp_reg >= RADIX) && (pos_reg != POS_W'(MAX_DIGITS - 1));
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            num_reg <= s_number;
            tmp_reg <= s_number;
            pos_reg <= '0;
            base_reg <= ADDR_BASE + ((s_row != 2'd0) ? ROW_STEP : 8'h00) + {2'b00, s_col};
        end else begin
            if (ctl.count) begin
                tmp_reg <= quot;
                pos_reg <= pos_reg + 1'b1;
            end
            if (ctl.dec_pos) begin
                pos_reg <= pos_reg - 1'b1;
            end
            if (ctl.div) begin
                q_reg <= quot;
            end
            if (ctl.rem) begin
                digit_reg <= 4'(num_reg - q_times10);
                num_reg <= q_reg;
            end
        end
        if (ctl.emit) begin
            m_rs_reg <= ctl.rs;
            m_value_reg <= xfer_val;
            m_last_reg <= ctl.last;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_reg_select = m_rs_reg;
    assign m_bus_value = m_value_reg;
    assign m_last = m_last_reg;

endmodule

// File: rtl/lcd_decimal_number_writer.sv
// Decimal number writer for a character LCD bus, microcoded control.
// An item with D digits goes through a load step and the digit-count loop, then per digit one divide,
// one remainder and four transfer steps, each transfer step waiting while the output is stalled.
// Eight-bit mode gives 2*D words, four-bit mode 4*D; skipped nibble steps are still stepped through.
// Output word is valid in the cycle after its step; next item is accepted once the last word is queued.
// Synchronous active-low reset: sequencer to wait step, output empty, bus_mode set to four-bit.
module lcd_decimal_number_writer import ldnw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_number,
    input  logic [1:0]  s_row,
    input  logic [5:0]  s_col,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic [7:0]  m_bus_value,
    output logic        m_last
);

    logic       bus_mode_reg;
    ldnw_ctl_t  ctl;
    ldnw_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            bus_mode_reg <= cfg_wdata;
        end
    end

    ldnw_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bus_mode (bus_mode_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ldnw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .stat         (stat),
        .s_number     (s_number),
        .s_row        (s_row),
        .s_col        (s_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_bus_value  (m_bus_value),
        .m_last       (m_last)
    );

endmodule
